// ----- rtl/deadline_ordered_timer_queue_top_macros.svh -----
// ----------------------------------------------------------------------------
// Timer queue assertion macros
// Concurrent property wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_TOP_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DOTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("timer queue check failed");
`define DOTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("timer queue check failed");
`else
`define DOTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define DOTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/dotq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer queue package
// Transaction types, status codes and key ordering.
// ----------------------------------------------------------------------------
`default_nettype none
package dotq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int RI_AW = 4;
  localparam int RI_CW = 5;

  localparam logic [1:0] ST_ADD   = 2'd0;
  localparam logic [1:0] ST_FIRED = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [62:0] DL_MAX = {63{1'b1}};

  typedef struct packed {
    logic        action;
    logic [62:0] time_us;
    logic [31:0] interval_us;
    logic [7:0]  timer_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fired_id;
    logic [62:0] fired_deadline_us;
    logic        rearm;
    logic [62:0] next_deadline_us;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [62:0] dl;
    logic [31:0] iv;
    logic [7:0]  id;
  } entry_t;

  typedef struct packed {
    logic [31:0] iv;
    logic [7:0]  id;
  } ri_t;

  function automatic logic key_after(input logic [62:0] da, input logic [7:0] ia,
                                     input logic [62:0] db, input logic [7:0] ib);
    return (da > db) || ((da == db) && (ia > ib));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dotq_ram.sv -----
// ----------------------------------------------------------------------------
// Timer queue RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/deadline_ordered_timer_queue_top.sv -----
// ----------------------------------------------------------------------------
// Deadline ordered timer queue
// Sorted timer store in a circular RAM with insertion walk and expire sweep.
// ----------------------------------------------------------------------------
// An add keeps busy high through a read, compare and write-back walk over each
// held entry that sorts after the new timer, on the queue RAM with its one read
// port and one write port. An add to a full queue never raises busy. An expire
// scans and pops each fired timer, up to MAX_RESULTS, then reloads each repeating
// timer and runs its insertion walk, and then finishes.
// busy falls in the cycle that shows the last result of a transaction, and the
// next transaction may be accepted at the edge that ends that cycle.
// Results appear on out_item for one cycle with out_strobe and cannot be held.
`default_nettype none
`include "deadline_ordered_timer_queue_top_macros.svh"
module deadline_ordered_timer_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire dotq_pkg::in_t in_item,
  output logic               out_strobe,
  output dotq_pkg::out_t     out_item
);
  import dotq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_POP_RD  = 8'b0000_0010,
    S_POP_CHK = 8'b0000_0100,
    S_RI_RD   = 8'b0000_1000,
    S_RI_LD   = 8'b0001_0000,
    S_INS_RD  = 8'b0010_0000,
    S_INS_CMP = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  hd_r, hd_nxt;
  logic [62:0]    head_dl_r, head_dl_nxt;
  entry_t         ins_r, ins_nxt;
  logic           exp_r, exp_nxt;
  logic           rearm_r, rearm_nxt;
  logic [62:0]    t_r, t_nxt;
  logic [RI_CW-1:0] n_r, n_nxt;
  logic [RI_CW-1:0] rn_r, rn_nxt;
  logic [RI_CW-1:0] rk_r, rk_nxt;
  logic [7:0]     pend_id_r, pend_id_nxt;
  logic [62:0]    pend_dl_r, pend_dl_nxt;
  out_t           out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic           q_we;
  logic [AW-1:0]  q_waddr, q_raddr;
  entry_t         q_wdata, q_rdata;
  logic           r_we;
  logic [RI_AW-1:0] r_waddr, r_raddr;
  ri_t            r_wdata, r_rdata;
  logic           ins_done;
  logic [63:0]    sum;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(p);
    if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
      s = s - (CW + 1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dotq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_addr (q_raddr),
    .rd_data (q_rdata)
  );

  dotq_ram #(.WIDTH($bits(ri_t)), .DEPTH(MAX_RESULTS)) u_reinsert_ram (
    .clk     (clk),
    .wr_en   (r_we),
    .wr_addr (r_waddr),
    .wr_data (r_wdata),
    .rd_addr (r_raddr),
    .rd_data (r_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    hd_nxt        = hd_r;
    head_dl_nxt   = head_dl_r;
    ins_nxt       = ins_r;
    exp_nxt       = exp_r;
    rearm_nxt     = rearm_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    rn_nxt        = rn_r;
    rk_nxt        = rk_r;
    pend_id_nxt   = pend_id_r;
    pend_dl_nxt   = pend_dl_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    q_we          = 1'b0;
    q_waddr       = phys(hd_r, pos_r);
    q_wdata       = ins_r;
    q_raddr       = hd_r;
    r_we          = 1'b0;
    r_waddr       = n_r[RI_AW-1:0];
    r_wdata       = '{iv: q_rdata.iv, id: q_rdata.id};
    r_raddr       = rk_r[RI_AW-1:0];
    ins_done      = 1'b0;
    sum           = {1'b0, t_r} + {32'd0, r_rdata.iv};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!in_item.action) begin
            if (cnt_r == CW'(QUEUE_DEPTH)) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{status: ST_FULL, fired_id: in_item.timer_id,
                          fired_deadline_us: in_item.time_us, rearm: 1'b0,
                          next_deadline_us: head_dl_r, last: 1'b1};
            end else begin
              ins_nxt   = '{dl: in_item.time_us, iv: in_item.interval_us,
                            id: in_item.timer_id};
              rearm_nxt = (cnt_r == '0) || (in_item.time_us < head_dl_r);
              exp_nxt   = 1'b0;
              pos_nxt   = cnt_r;
              state_nxt = S_INS_RD;
            end
          end else begin
            t_nxt     = in_item.time_us;
            exp_nxt   = 1'b1;
            n_nxt     = '0;
            rn_nxt    = '0;
            state_nxt = S_POP_RD;
          end
        end
      end
      S_POP_RD: begin
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        if ((cnt_r != '0) && (n_r < RI_CW'(MAX_RESULTS)) && (q_rdata.dl <= t_r)) begin
          hd_nxt  = phys(hd_r, CW'(1));
          cnt_nxt = cnt_r - CW'(1);
          n_nxt   = n_r + RI_CW'(1);
          if (n_r != '0) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{status: ST_FIRED, fired_id: pend_id_r,
                        fired_deadline_us: pend_dl_r, rearm: 1'b0,
                        next_deadline_us: '0, last: 1'b0};
          end
          pend_id_nxt = q_rdata.id;
          pend_dl_nxt = q_rdata.dl;
          if (q_rdata.iv != '0) begin
            r_we   = 1'b1;
            r_waddr = rn_r[RI_AW-1:0];
            rn_nxt = rn_r + RI_CW'(1);
          end
          state_nxt = S_POP_RD;
        end else begin
          if (cnt_r != '0) begin
            head_dl_nxt = q_rdata.dl;
          end
          if (n_r == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{status: ST_NONE, fired_id: '0, fired_deadline_us: '0,
                        rearm: (cnt_r != '0),
                        next_deadline_us: (cnt_r != '0) ? q_rdata.dl : 63'd0,
                        last: 1'b1};
            state_nxt = S_IDLE;
          end else begin
            rk_nxt    = '0;
            state_nxt = S_RI_RD;
          end
        end
      end
      S_RI_RD: begin
        if (rk_r == rn_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RI_LD;
        end
      end
      S_RI_LD: begin
        ins_nxt   = '{dl: sum[63] ? DL_MAX : sum[62:0], iv: r_rdata.iv, id: r_rdata.id};
        rk_nxt    = rk_r + RI_CW'(1);
        pos_nxt   = cnt_r;
        state_nxt = S_INS_RD;
      end
      S_INS_RD: begin
        if (pos_r == '0) begin
          q_we     = 1'b1;
          ins_done = 1'b1;
        end else begin
          q_raddr   = phys(hd_r, pos_r - CW'(1));
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        q_we = 1'b1;
        if (key_after(q_rdata.dl, q_rdata.id, ins_r.dl, ins_r.id)) begin
          q_wdata   = q_rdata;
          pos_nxt   = pos_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          ins_done = 1'b1;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_nxt = '{status: ST_FIRED, fired_id: pend_id_r, fired_deadline_us: pend_dl_r,
                    rearm: (cnt_r != '0),
                    next_deadline_us: (cnt_r != '0) ? head_dl_r : 63'd0, last: 1'b1};
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ins_done) begin
      cnt_nxt = cnt_r + CW'(1);
      if (pos_r == '0) begin
        head_dl_nxt = ins_r.dl;
      end
      if (exp_r) begin
        state_nxt = S_RI_RD;
      end else begin
        out_valid_nxt = 1'b1;
        out_nxt = '{status: ST_ADD, fired_id: ins_r.id, fired_deadline_us: ins_r.dl,
                    rearm: rearm_r,
                    next_deadline_us: (pos_r == '0) ? ins_r.dl : head_dl_r, last: 1'b1};
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hd_r        <= hd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r     <= pos_nxt;
    head_dl_r <= head_dl_nxt;
    ins_r     <= ins_nxt;
    exp_r     <= exp_nxt;
    rearm_r   <= rearm_nxt;
    t_r       <= t_nxt;
    n_r       <= n_nxt;
    rn_r      <= rn_nxt;
    rk_r      <= rk_nxt;
    pend_id_r <= pend_id_nxt;
    pend_dl_r <= pend_dl_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  `DOTQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(QUEUE_DEPTH))
  `DOTQ_ASSERT_NOW(a_last_idle, clk, rst_n, out_valid_r && out_r.last, !busy)
  `DOTQ_ASSERT_NEXT(a_full_no_change, clk, rst_n,
                    start && !busy && !in_item.action && (cnt_r == CW'(QUEUE_DEPTH)),
                    !busy && (cnt_r == CW'(QUEUE_DEPTH)))
  `DOTQ_ASSERT_NOW(a_fire_bound, clk, rst_n, busy, n_r <= RI_CW'(MAX_RESULTS))

endmodule
`default_nettype wire
